FILE: hw/rtl/bbi_pkg.sv
// Package for the 3x3 box blur: shared types, register and command codes,
// and the reciprocal constant used for the divide by nine.
// No dependencies.
package bbi_pkg;

    localparam int PIX_W  = 8;   // pixel intensity
    localparam int CSUM_W = 10;  // sum of one three-pixel column
    localparam int SUM_W  = 12;  // sum of the full 3x3 window
    localparam int REG_W  = 9;   // configuration register width
    localparam int ROW_W  = 8;   // row counter, up to 256 lines

    // Register reset values and limits
    localparam logic [REG_W-1:0] LINE_LENGTH_RST = 9'd28;
    localparam logic [REG_W-1:0] LINE_COUNT_RST  = 9'd28;
    localparam logic [REG_W-1:0] COUNT_MAX       = 9'd256;

    // Register index codes (address bit 2)
    localparam logic REG_LINE_LENGTH = 1'b0;
    localparam logic REG_LINE_COUNT  = 1'b1;

    // Input command codes
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    // floor(s / 9) == (s * 3641) >> 15 for every 12-bit window sum
    localparam logic [SUM_W-1:0] DIV9_MUL   = 12'd3641;
    localparam int               DIV9_SHIFT = 15;

    // Operation held in the store access stage
    typedef enum logic [1:0] {
        OP_NONE,
        OP_PIXEL,
        OP_DRAIN
    } t_op;

    // One line store word: the two lines above the current input line
    typedef struct packed {
        logic [PIX_W-1:0] top;     // one line up
        logic [PIX_W-1:0] bottom;  // two lines up
    } t_store_word;

endpackage

FILE: hw/rtl/bbi_line_store.sv
// Line store for the 3x3 box blur: one word per column, synchronous read
// with a registered output and write-to-read forwarding.
// Depends on bbi_pkg.
module bbi_line_store import bbi_pkg::*; #(
    parameter int DEPTH = 256
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]   i_rd_addr,
    input  logic                       i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]   i_wr_addr,
    input  t_store_word                i_wr_data,
    output t_store_word                o_rd_data
);

    t_store_word r_mem [DEPTH];
    t_store_word r_rd;
    t_store_word r_fwd_data;
    logic        r_fwd_v;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, held until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    // Capture a write that lands on the entry being read in the same cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_v <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd_v <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_fwd_data <= i_wr_data;
        end
    end

    assign o_rd_data = r_fwd_v ? r_fwd_data : r_rd;

endmodule

FILE: hw/rtl/box_blur_3x3_interior.sv
// Streaming 3x3 box blur over a frame of 8-bit pixels in scan order.
// Depends on bbi_pkg and bbi_line_store.
//
// The block takes one item per clock while o_in_stall is low, pixels and
// drain commands alike; a result passes the store access and sum stages
// into the output register. Each interior pixel becomes the truncated sum
// of its 3x3 neighborhood divided by nine; border pixels pass through
// unchanged. A result trails its pixel by one line plus one pixel, and
// once the frame's last pixel is in, each drain command pushes out one
// pending result; the last one carries frame_last and restarts the frame.
// The line store holds MAX_LINE words of two pixels, read and written once
// per cycle, which sets the one-item-per-clock rate; it needs no clearing
// after reset. Writing either register restarts the frame. line_length is
// clamped to 1..MAX_LINE and line_count to 1..256.
module box_blur_3x3_interior import bbi_pkg::*; #(
    parameter int MAX_LINE = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input items
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_cmd,
    input  logic [PIX_W-1:0]   i_pixel_in,
    // result items
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [PIX_W-1:0]   o_pixel_out,
    output logic               o_frame_last,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int              CW           = $clog2(MAX_LINE);
    localparam logic [CW-1:0]   LAST_COL_MAX = CW'(MAX_LINE - 1);

    // Configuration
    logic [REG_W-1:0] r_line_length;
    logic [REG_W-1:0] r_line_count;
    logic             w_cfg_wr;
    logic [CW-1:0]    w_len_m1;
    logic [ROW_W-1:0] w_cnt_m1;

    // Frame position
    logic [CW-1:0]    r_in_col,  n_in_col;
    logic [ROW_W-1:0] r_in_line, n_in_line;
    logic [CW-1:0]    r_out_col, n_out_col;
    logic [ROW_W-1:0] r_out_row, n_out_row;
    logic             r_done,    n_done;

    // Item decode
    logic             w_acc;
    t_op              w_op;
    logic             w_emit;
    logic             w_is_last;
    logic             w_is_int;
    logic             w_top_sel;
    logic [CW-1:0]    w_rd_addr;

    // Store access stage
    t_op              r_s1_op;
    logic [CW-1:0]    r_s1_addr;
    logic [PIX_W-1:0] r_s1_pixel;
    logic             r_s1_emit;
    logic             r_s1_int;
    logic             r_s1_last;
    logic             r_s1_top;
    logic             w_s1_go;
    logic             w_s1_free;
    t_store_word      w_rd_data;
    t_store_word      w_wr_data;
    logic             w_wr_en;
    logic [CSUM_W-1:0] w_col_sum;
    logic [SUM_W-1:0] w_sum9;
    logic [PIX_W-1:0] w_border;

    // Window of column sums and the center pixel
    logic [CSUM_W-1:0] r_w1_sum;
    logic [CSUM_W-1:0] r_w2_sum;
    logic [PIX_W-1:0]  r_w2_mid;

    // Sum stage
    logic             r_s2_v;
    logic [SUM_W-1:0] r_s2_sum;
    logic [PIX_W-1:0] r_s2_border;
    logic             r_s2_int;
    logic             r_s2_last;
    logic             w_s2_free;
    logic [2*SUM_W-1:0] w_prod;

    // Output register
    logic             r_out_v;
    logic [PIX_W-1:0] r_out_pixel;
    logic             r_out_last;
    logic             w_out_free;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_length <= LINE_LENGTH_RST;
            r_line_count  <= LINE_COUNT_RST;
        end else if (w_cfg_wr) begin
            case (paddr[2])
                REG_LINE_LENGTH: r_line_length <= pwdata[REG_W-1:0];
                REG_LINE_COUNT:  r_line_count  <= pwdata[REG_W-1:0];
                default:         r_line_length <= r_line_length;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_LINE_LENGTH: prdata = {{(32-REG_W){1'b0}}, r_line_length};
            REG_LINE_COUNT:  prdata = {{(32-REG_W){1'b0}}, r_line_count};
            default:         prdata = '0;
        endcase
    end

    // Clamp the registers to the last column and last row index
    always_comb begin
        if (r_line_length == '0) begin
            w_len_m1 = '0;
        end else if (32'(r_line_length) > MAX_LINE) begin
            w_len_m1 = LAST_COL_MAX;
        end else begin
            w_len_m1 = CW'(r_line_length - 9'd1);
        end
        if (r_line_count == '0) begin
            w_cnt_m1 = '0;
        end else if (r_line_count > COUNT_MAX) begin
            w_cnt_m1 = '1;
        end else begin
            w_cnt_m1 = ROW_W'(r_line_count - 9'd1);
        end
    end

    // ------------------------------------------------------------------
    // Handshake: each stage moves when the one after it has room
    // ------------------------------------------------------------------
    assign w_out_free = !r_out_v || !i_out_stall;
    assign w_s2_free  = !r_s2_v || w_out_free;
    assign w_s1_go    = (r_s1_op != OP_NONE) && (!r_s1_emit || w_s2_free);
    assign w_s1_free  = (r_s1_op == OP_NONE) || w_s1_go;
    assign o_in_stall = !w_s1_free;
    assign w_acc      = i_in_valid && w_s1_free;

    // ------------------------------------------------------------------
    // Item decode against the frame position
    // ------------------------------------------------------------------
    always_comb begin
        if (i_cmd == CMD_PIXEL && !r_done) begin
            w_op = OP_PIXEL;
        end else if (i_cmd == CMD_DRAIN && r_done) begin
            w_op = OP_DRAIN;
        end else begin
            w_op = OP_NONE;
        end
    end

    always_comb begin
        case (w_op)
            // a pixel yields a result once one line plus one pixel is in
            OP_PIXEL: w_emit = (r_in_line != '0) &&
                               ((r_in_line != ROW_W'(1)) || (r_in_col != '0));
            OP_DRAIN: w_emit = 1'b1;
            default:  w_emit = 1'b0;
        endcase
    end

    assign w_is_last = (r_out_row == w_cnt_m1) && (r_out_col == w_len_m1);
    assign w_is_int  = (w_op == OP_PIXEL) &&
                       (r_out_row != '0) && (r_out_row < w_cnt_m1) &&
                       (r_out_col != '0) && (r_out_col < w_len_m1);
    assign w_top_sel = (r_out_row == w_cnt_m1);
    assign w_rd_addr = (w_op == OP_DRAIN) ? r_out_col : r_in_col;

    // Advance input and output positions
    always_comb begin
        n_in_col  = r_in_col;
        n_in_line = r_in_line;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        n_done    = r_done;
        if (w_cfg_wr) begin
            n_in_col  = '0;
            n_in_line = '0;
            n_out_col = '0;
            n_out_row = '0;
            n_done    = 1'b0;
        end else if (w_acc) begin
            if (w_op == OP_PIXEL) begin
                if (r_in_col == w_len_m1) begin
                    n_in_col = '0;
                    if (r_in_line == w_cnt_m1) begin
                        n_in_line = '0;
                        n_done    = 1'b1;
                    end else begin
                        n_in_line = r_in_line + 1'b1;
                    end
                end else begin
                    n_in_col = r_in_col + 1'b1;
                end
            end
            if (w_emit) begin
                if (w_is_last) begin
                    n_in_col  = '0;
                    n_in_line = '0;
                    n_out_col = '0;
                    n_out_row = '0;
                    n_done    = 1'b0;
                end else if (r_out_col == w_len_m1) begin
                    n_out_col = '0;
                    n_out_row = r_out_row + 1'b1;
                end else begin
                    n_out_col = r_out_col + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_line <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_done    <= 1'b0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_line <= n_in_line;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            r_done    <= n_done;
        end
    end

    // ------------------------------------------------------------------
    // Store access stage: read at accept, write back when a pixel item leaves
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_op <= OP_NONE;
        end else if (w_s1_free) begin
            r_s1_op <= w_acc ? w_op : OP_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_addr  <= w_rd_addr;
            r_s1_pixel <= i_pixel_in;
            r_s1_emit  <= w_emit;
            r_s1_int   <= w_is_int;
            r_s1_last  <= w_is_last;
            r_s1_top   <= w_top_sel;
        end
    end

    assign w_wr_en   = w_s1_go && (r_s1_op == OP_PIXEL);
    assign w_wr_data = '{top: r_s1_pixel, bottom: w_rd_data.top};

    bbi_line_store #(
        .DEPTH (MAX_LINE)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_acc),
        .i_rd_addr (w_rd_addr),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (w_wr_data),
        .o_rd_data (w_rd_data)
    );

    // New column: two lines from the store plus the incoming pixel
    assign w_col_sum = CSUM_W'(w_rd_data.top) + CSUM_W'(w_rd_data.bottom) +
                       CSUM_W'(r_s1_pixel);
    assign w_sum9    = SUM_W'(r_w1_sum) + SUM_W'(r_w2_sum) + SUM_W'(w_col_sum);

    // Border value: window center for pixels, stored line for drains
    always_comb begin
        case (r_s1_op)
            OP_DRAIN: w_border = r_s1_top ? w_rd_data.top : w_rd_data.bottom;
            default:  w_border = r_w2_mid;
        endcase
    end

    // Shift the column window on every stored pixel
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_w1_sum <= r_w2_sum;
            r_w2_sum <= w_col_sum;
            r_w2_mid <= w_rd_data.top;
        end
    end

    // ------------------------------------------------------------------
    // Sum stage
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (w_s1_go && r_s1_emit) begin
            r_s2_v <= 1'b1;
        end else if (w_out_free) begin
            r_s2_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_go && r_s1_emit) begin
            r_s2_sum    <= w_sum9;
            r_s2_border <= w_border;
            r_s2_int    <= r_s1_int;
            r_s2_last   <= r_s1_last;
        end
    end

    // ------------------------------------------------------------------
    // Divide by nine and hold the result for transfer
    // ------------------------------------------------------------------
    assign w_prod = r_s2_sum * DIV9_MUL;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_out_free) begin
            r_out_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && r_s2_v) begin
            r_out_pixel <= r_s2_int ? w_prod[DIV9_SHIFT +: PIX_W] : r_s2_border;
            r_out_last  <= r_s2_last;
        end
    end

    assign o_out_valid  = r_out_v;
    assign o_pixel_out  = r_out_pixel;
    assign o_frame_last = r_out_last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_stall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_op == OP_NONE) |-> !o_in_stall)
        else $error("input stalled with an empty store stage");

    a_done_input_parked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_in_col == '0 && r_in_line == '0))
        else $error("input position moved after the frame input completed");

    a_out_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_row <= w_cnt_m1) && (r_out_col <= w_len_m1))
        else $error("output position outside the frame");

    a_cfg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(w_cfg_wr) |-> (r_out_row == '0 && r_out_col == '0 && !r_done))
        else $error("register write did not restart the frame");

endmodule
